[sv/apq_pkg.sv]
// Shared types, codes and default sizes for the aging priority queue.
`default_nettype none

package apq_pkg;

    // Default sizes handed to the top level parameters.
    localparam int APQ_DEPTH     = 16;
    localparam int APQ_PRIO_BITS = 8;
    localparam int APQ_TAG_BITS  = 16;

    // Operation codes carried in the func field.
    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_SERVE  = 2'd1;
    localparam logic [1:0] FUNC_AGE    = 2'd2;
    localparam logic [1:0] FUNC_REMOVE = 2'd3;

    // Status codes returned with every result.
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Input transaction payload.
    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] entry_tag;
        logic [7:0]  entry_priority;
    } apq_in_t;

    // Result transaction payload.
    typedef struct packed {
        logic [15:0] served_tag;
        logic [15:0] head_tag;
        logic [7:0]  head_priority;
        logic [4:0]  occupancy;
        logic [1:0]  status;
    } apq_out_t;

    // Commands broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;  // open a gap at the insert point and place the new entry
        logic shift;   // every cell takes its right neighbor
        logic recirc;  // the last occupied cell takes the old head with priority 0
        logic age;     // priorities moving left are aged on the way
    } apq_cell_ctrl_t;

endpackage

`default_nettype wire

[sv/apq_cell.sv]
// One slot of the sorted chain: holds a tag and a priority and trades with its neighbors.
`default_nettype none

module apq_cell
    import apq_pkg::*;
#(
    parameter int TAG_BITS  = APQ_TAG_BITS,
    parameter int PRIO_BITS = APQ_PRIO_BITS
) (
    input  wire logic                 aclk,
    input  wire apq_cell_ctrl_t       ctrl,
    input  wire logic                 occupied,
    input  wire logic                 is_last,
    input  wire logic                 left_ge,
    input  wire logic [TAG_BITS-1:0]  left_tag,
    input  wire logic [PRIO_BITS-1:0] left_prio,
    input  wire logic [TAG_BITS-1:0]  right_tag,
    input  wire logic [PRIO_BITS-1:0] right_prio,
    input  wire logic [TAG_BITS-1:0]  new_tag,
    input  wire logic [PRIO_BITS-1:0] new_prio,
    input  wire logic [TAG_BITS-1:0]  head_tag,
    output logic                      ge,
    output logic [TAG_BITS-1:0]       tag,
    output logic [PRIO_BITS-1:0]      prio,
    output logic [TAG_BITS-1:0]       tag_next,
    output logic [PRIO_BITS-1:0]      prio_next
);

    logic [TAG_BITS-1:0]  tag_reg;
    logic [PRIO_BITS-1:0] prio_reg;
    logic [PRIO_BITS-1:0] right_prio_aged;

    // An occupied slot whose priority is at least the new one stays ahead of it.
    assign ge = occupied && (prio_reg >= new_prio);

    // Saturating age step; a priority of zero marks an entry already served.
    always_comb begin
        if (ctrl.age && (right_prio != '0) && (right_prio != '1)) begin
            right_prio_aged = right_prio + PRIO_BITS'(1);
        end else begin
            right_prio_aged = right_prio;
        end
    end

    // Next slot contents.
    always_comb begin
        tag_next  = tag_reg;
        prio_next = prio_reg;
        if (ctrl.insert) begin
            if (ge) begin
                tag_next  = tag_reg;
                prio_next = prio_reg;
            end else if (left_ge) begin
                tag_next  = new_tag;
                prio_next = new_prio;
            end else begin
                tag_next  = left_tag;
                prio_next = left_prio;
            end
        end else if (ctrl.shift) begin
            if (ctrl.recirc && is_last) begin
                tag_next  = head_tag;
                prio_next = '0;
            end else begin
                tag_next  = right_tag;
                prio_next = right_prio_aged;
            end
        end
    end

    // Slot storage; contents are meaningful only below the entry count.
    always_ff @(posedge aclk) begin
        tag_reg  <= tag_next;
        prio_reg <= prio_next;
    end

    assign tag  = tag_reg;
    assign prio = prio_reg;

endmodule

`default_nettype wire

[sv/aging_priority_queue.sv]
// Top level of the aging priority queue: chain of sorted cells, entry count and result register.
//
//   Channel   Ports                     Payload     Direction
//   input     s_valid s_ready s_data    apq_in_t    in
//   result    m_valid m_ready m_data    apq_out_t   out
//
// Every operation is done by all cells comparing and shifting together,
// and the result is registered, visible in the cycle after the transaction is accepted.
// One transaction per cycle is sustained while results are taken; s_ready drops
// only while a result waits in the output register and m_ready is low.
// Reset (aresetn low, synchronous) empties the queue and the output register;
// slot contents are not cleared and are never shown while unoccupied.
`default_nettype none

module aging_priority_queue
    import apq_pkg::*;
#(
    parameter int DEPTH     = APQ_DEPTH,
    parameter int PRIO_BITS = APQ_PRIO_BITS,
    parameter int TAG_BITS  = APQ_TAG_BITS
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire apq_in_t  s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output apq_out_t      m_data
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                 accept;
    logic                 full;
    logic                 empty;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    apq_cell_ctrl_t       ctrl;

    logic [TAG_BITS+15:0]  in_tag_ext;
    logic [PRIO_BITS+7:0]  in_prio_ext;
    logic [TAG_BITS-1:0]   new_tag;
    logic [PRIO_BITS-1:0]  new_prio;

    logic [TAG_BITS-1:0]  cell_tag       [DEPTH];
    logic [PRIO_BITS-1:0] cell_prio      [DEPTH];
    logic [TAG_BITS-1:0]  cell_tag_next  [DEPTH];
    logic [PRIO_BITS-1:0] cell_prio_next [DEPTH];
    logic [DEPTH-1:0]     cell_ge;

    logic [TAG_BITS+15:0]  served_ext;
    logic [TAG_BITS+15:0]  head_tag_ext;
    logic [PRIO_BITS+7:0]  head_prio_ext;
    logic [CNT_W+4:0]      count_ext;
    logic [1:0]            status;
    logic                  has_served;
    apq_out_t              result;

    logic     out_valid_reg;
    apq_out_t out_data_reg;

    // Handshake and queue state flags.
    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);

    // Fit the incoming tag and priority to the stored widths.
    assign in_tag_ext  = {{TAG_BITS{1'b0}}, s_data.entry_tag};
    assign in_prio_ext = {{PRIO_BITS{1'b0}}, s_data.entry_priority};
    assign new_tag     = in_tag_ext[TAG_BITS-1:0];
    assign new_prio    = in_prio_ext[PRIO_BITS-1:0];

    // Commands for the chain.
    always_comb begin
        ctrl.insert = accept && (s_data.func == FUNC_INSERT) && !full;
        ctrl.shift  = accept && (s_data.func != FUNC_INSERT) && !empty;
        ctrl.recirc = (s_data.func == FUNC_SERVE) || (s_data.func == FUNC_AGE);
        ctrl.age    = (s_data.func == FUNC_AGE);
    end

    // The chain of slots.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic                 left_ge;
        logic [TAG_BITS-1:0]  left_tag;
        logic [PRIO_BITS-1:0] left_prio;
        logic [TAG_BITS-1:0]  right_tag;
        logic [PRIO_BITS-1:0] right_prio;

        if (i == 0) begin : g_first
            assign left_ge   = 1'b1;
            assign left_tag  = new_tag;
            assign left_prio = new_prio;
        end else begin : g_inner
            assign left_ge   = cell_ge[i-1];
            assign left_tag  = cell_tag[i-1];
            assign left_prio = cell_prio[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign right_tag  = cell_tag[i];
            assign right_prio = cell_prio[i];
        end else begin : g_body
            assign right_tag  = cell_tag[i+1];
            assign right_prio = cell_prio[i+1];
        end

        apq_cell #(
            .TAG_BITS  (TAG_BITS),
            .PRIO_BITS (PRIO_BITS)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .occupied   (CNT_W'(i) < count_reg),
            .is_last    (count_reg == CNT_W'(i + 1)),
            .left_ge    (left_ge),
            .left_tag   (left_tag),
            .left_prio  (left_prio),
            .right_tag  (right_tag),
            .right_prio (right_prio),
            .new_tag    (new_tag),
            .new_prio   (new_prio),
            .head_tag   (cell_tag[0]),
            .ge         (cell_ge[i]),
            .tag        (cell_tag[i]),
            .prio       (cell_prio[i]),
            .tag_next   (cell_tag_next[i]),
            .prio_next  (cell_prio_next[i])
        );
    end

    // Entry count update.
    always_comb begin
        count_next = count_reg;
        if (ctrl.insert) begin
            count_next = count_reg + CNT_W'(1);
        end else if (ctrl.shift && (s_data.func == FUNC_REMOVE)) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Result fields; served tag and status use the state before, the rest the state left behind.
    always_comb begin
        if ((s_data.func == FUNC_INSERT) && full) begin
            status = ST_FULL;
        end else if ((s_data.func != FUNC_INSERT) && empty) begin
            status = ST_EMPTY;
        end else begin
            status = ST_DONE;
        end
    end

    assign has_served    = ctrl.shift;
    assign served_ext    = {{16{1'b0}}, has_served ? cell_tag[0] : {TAG_BITS{1'b0}}};
    assign head_tag_ext  = {{16{1'b0}},
                            (count_next != '0) ? cell_tag_next[0] : {TAG_BITS{1'b0}}};
    assign head_prio_ext = {{8{1'b0}},
                            (count_next != '0) ? cell_prio_next[0] : {PRIO_BITS{1'b0}}};
    assign count_ext     = {5'b0, count_next};

    always_comb begin
        result.served_tag    = served_ext[15:0];
        result.head_tag      = head_tag_ext[15:0];
        result.head_priority = head_prio_ext[7:0];
        result.occupancy     = count_ext[4:0];
        result.status        = status;
    end

    // Output register; a waiting result does not block a new transaction that
    // is accepted in the same cycle the result is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_data_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // The entry count never passes the number of slots.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count exceeds queue depth");

    // A successful insert adds exactly one entry.
    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.insert |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not add one entry");

    // Serving and aging recirculate the head, so the count is unchanged.
    a_serve_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.shift && ctrl.recirc) |=> (count_reg == $past(count_reg)))
        else $error("serve changed the entry count");

    // Every accepted transaction yields a result in the next cycle.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("accepted transaction produced no result");

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for the aging priority queue with a sorted-queue shadow model.
`timescale 1ns / 100ps

module testbench;
    import apq_pkg::*;

    localparam int          RANDOM_ITEMS = 1930;
    localparam int          QUIET_ITEMS  = 200;
    localparam int          LONG_HOLD    = 120;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam logic [7:0]  PRIO_TOP     = 8'((1 << APQ_PRIO_BITS) - 1);

    // Shadow of the sorted queue and the results it still owes.
    class sorted_queue_shadow;
        logic [15:0] slot_tag  [APQ_DEPTH];
        logic [7:0]  slot_prio [APQ_DEPTH];
        int unsigned count;
        int unsigned failures;
        apq_out_t    pending_results [$];

        function new();
            count    = 0;
            failures = 0;
        endfunction

        task report(input string msg);
            $display("ERROR at %0t: %s", $realtime, msg);
            failures++;
        endtask

        // Shift every entry one place toward the head, dropping the head.
        function void drop_head();
            for (int i = 1; i < count; i++) begin
                slot_tag[i-1]  = slot_tag[i];
                slot_prio[i-1] = slot_prio[i];
            end
            count--;
        endfunction

        // Apply one accepted input transaction and queue the result it must produce.
        function void note_request(input apq_in_t req);
            apq_out_t    res;
            logic [15:0] served;
            logic [15:0] head;
            logic [7:0]  prio;
            logic [1:0]  status;
            int          pos;
            served = '0;
            status = ST_DONE;
            prio   = req.entry_priority & PRIO_TOP;
            if (req.func == FUNC_INSERT) begin
                if (count >= APQ_DEPTH) begin
                    status = ST_FULL;
                end else begin
                    // Equal priorities keep arrival order: go after all of them.
                    pos = 0;
                    while (pos < count && slot_prio[pos] >= prio) pos++;
                    for (int i = count; i > pos; i--) begin
                        slot_tag[i]  = slot_tag[i-1];
                        slot_prio[i] = slot_prio[i-1];
                    end
                    slot_tag[pos]  = req.entry_tag;
                    slot_prio[pos] = prio;
                    count++;
                end
            end else if (count == 0) begin
                status = ST_EMPTY;
            end else if (req.func == FUNC_REMOVE) begin
                served = slot_tag[0];
                drop_head();
            end else begin
                // Aging skips served entries and saturates at the top priority.
                if (req.func == FUNC_AGE) begin
                    for (int i = 0; i < count; i++) begin
                        if (slot_prio[i] != 0 && slot_prio[i] < PRIO_TOP) begin
                            slot_prio[i] = slot_prio[i] + 8'd1;
                        end
                    end
                end
                head = slot_tag[0];
                drop_head();
                slot_tag[count]  = head;
                slot_prio[count] = '0;
                count++;
                served = head;
            end
            res.served_tag    = served;
            res.head_tag      = (count != 0) ? slot_tag[0] : '0;
            res.head_priority = (count != 0) ? slot_prio[0] : '0;
            res.occupancy     = 5'(count);
            res.status        = status;
            pending_results.push_back(res);
        endfunction

        // Compare one result transaction with the oldest expectation.
        task check_result(input apq_out_t got);
            apq_out_t want;
            if (pending_results.size() == 0) begin
                report($sformatf("result with nothing expected: %h", got));
            end else begin
                want = pending_results.pop_front();
                if (got.served_tag !== want.served_tag)
                    report($sformatf("served_tag %h, expected %h",
                                     got.served_tag, want.served_tag));
                if (got.head_tag !== want.head_tag)
                    report($sformatf("head_tag %h, expected %h",
                                     got.head_tag, want.head_tag));
                if (got.head_priority !== want.head_priority)
                    report($sformatf("head_priority %h, expected %h",
                                     got.head_priority, want.head_priority));
                if (got.occupancy !== want.occupancy)
                    report($sformatf("occupancy %0d, expected %0d",
                                     got.occupancy, want.occupancy));
                if (got.status !== want.status)
                    report($sformatf("status %0d, expected %0d", got.status, want.status));
            end
        endtask
    endclass

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    apq_in_t     s_data  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    apq_out_t    m_data;

    int unsigned cycle_count    = 0;
    int unsigned items_sent     = 0;
    int unsigned hold_left      = 0;
    logic        long_hold_done = 1'b0;
    logic        no_idle        = 1'b0;

    sorted_queue_shadow shadow = new();

    aging_priority_queue dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Clock generation.
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Cycle counter and run limit.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result receiver: random stall bursts, one long hold-off, none near the end.
    always @(posedge aclk) begin
        if (!long_hold_done && items_sent >= 700) begin
            long_hold_done <= 1'b1;
            hold_left      <= LONG_HOLD;
            m_ready        <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (no_idle || cycle_count[8] || $urandom_range(0, 5) != 0) begin
            m_ready <= 1'b1;
        end else begin
            hold_left <= $urandom_range(0, 6);
            m_ready   <= 1'b0;
        end
    end

    // Result monitor.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) shadow.check_result(m_data);
    end

    // Offer one transaction and hold it until the queue accepts it.
    task automatic send_item(input apq_in_t item);
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        shadow.note_request(item);
        items_sent++;
    endtask

    task automatic idle_sender(input int unsigned cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    function automatic apq_in_t make_item(input logic [1:0] func, input logic [15:0] tag,
                                          input logic [7:0] prio);
        apq_in_t item;
        item.func           = func;
        item.entry_tag      = tag;
        item.entry_priority = prio;
        return item;
    endfunction

    // Random operation mix; priorities cluster to force ties and saturation.
    function automatic apq_in_t random_item(input int unsigned insert_pct);
        apq_in_t     item;
        int unsigned roll;
        item.entry_tag = 16'($urandom);
        case ($urandom_range(0, 9))
            0:       item.entry_priority = '0;
            1:       item.entry_priority = '1;
            2, 3, 4: item.entry_priority = 8'($urandom_range(100, 103));
            default: item.entry_priority = 8'($urandom);
        endcase
        roll = $urandom_range(0, 9);
        if ($urandom_range(0, 99) < insert_pct) item.func = FUNC_INSERT;
        else if (roll < 4)                      item.func = FUNC_AGE;
        else if (roll < 7)                      item.func = FUNC_SERVE;
        else                                    item.func = FUNC_REMOVE;
        return item;
    endfunction

    initial begin
        static logic [15:0] tags  [16] = '{16'hFFFF, 16'h0000, 16'h1111, 16'h2222,
                                           16'h3333, 16'hAAAA, 16'h5555, 16'h0001,
                                           16'h8000, 16'h7FFF, 16'h4444, 16'h0F0F,
                                           16'hF0F0, 16'h1234, 16'h6789, 16'hC3C3};
        static logic [7:0]  prios [16] = '{8'd255, 8'd0,   8'd100, 8'd100,
                                           8'd100, 8'd254, 8'd1,   8'd255,
                                           8'd128, 8'd127, 8'd100, 8'd2,
                                           8'd253, 8'd0,   8'd200, 8'd50};
        int unsigned insert_pct;
        int unsigned idle_pct;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Operations on an empty queue.
        send_item(make_item(FUNC_SERVE, 16'hABCD, 8'd7));
        send_item(make_item(FUNC_AGE, 16'h0000, 8'd0));
        send_item(make_item(FUNC_REMOVE, 16'hFFFF, 8'hFF));

        // Fill to capacity with extreme and tied priorities.
        for (int i = 0; i < 16; i++) send_item(make_item(FUNC_INSERT, tags[i], prios[i]));

        // Insert into a full queue, then age with saturation, serve and remove.
        send_item(make_item(FUNC_INSERT, 16'h9999, 8'd9));
        send_item(make_item(FUNC_AGE, 16'h0000, 8'd0));
        send_item(make_item(FUNC_SERVE, 16'h0000, 8'd0));
        send_item(make_item(FUNC_REMOVE, 16'h0000, 8'd0));

        // Random phases with changing insert bias and sender idling.
        insert_pct = 50;
        idle_pct   = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 150 == 0) begin
                case ($urandom_range(0, 3))
                    0:       insert_pct = 25;
                    1:       insert_pct = 50;
                    2:       insert_pct = 75;
                    default: insert_pct = 90;
                endcase
                idle_pct = 20 * $urandom_range(0, 2);
            end
            // Let all outstanding results drain once before going on.
            if (n == 1100) begin
                s_valid <= 1'b0;
                do @(posedge aclk); while (shadow.pending_results.size() != 0);
            end
            if (n >= RANDOM_ITEMS - QUIET_ITEMS) begin
                no_idle = 1'b1;
            end else if ($urandom_range(0, 99) < idle_pct) begin
                idle_sender($urandom_range(1, 7));
            end
            send_item(random_item(insert_pct));
        end

        // Wait for the last results, then keep watching for stray ones.
        s_valid <= 1'b0;
        while (shadow.pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (shadow.failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
